### design/hrsz_pkg.sv
package hrsz_pkg;

	// Accumulator widths
	localparam int COUNT_WIDTH = 32;
	localparam int SUM_WIDTH   = 48;
	localparam int CNT_BITS    = $clog2(SUM_WIDTH);

	localparam int RATE_WIDTH  = 16;
	localparam int ZONE_COUNT  = 5;
	localparam int ZONE_WIDTH  = 3;
	localparam int CFG_WIDTH   = 32;
	localparam int IDX_WIDTH   = $clog2(ZONE_COUNT);
	localparam int TOTAL_WIDTH = 32;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// Flag bit positions
	localparam int FLAG_WIDE_BIT = 0;

	// Contact field codes, raw and reported
	localparam logic [1:0] CONTACT_RAW_NONE   = 2'b10;
	localparam logic [1:0] CONTACT_RAW_SEEN   = 2'b11;
	localparam logic [1:0] CONTACT_UNSUPPORTED = 2'd0;
	localparam logic [1:0] CONTACT_NO_CONTACT  = 2'd1;
	localparam logic [1:0] CONTACT_DETECTED    = 2'd2;

	typedef struct packed {
		logic accept;
		logic zone_en;
		logic div_start;
		logic mean_load;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic acc_taken;
		logic div_done;
	} sts_t;

	typedef struct packed {
		logic [RATE_WIDTH-1:0]  heart_rate;
		logic [RATE_WIDTH-1:0]  minimum_rate;
		logic [RATE_WIDTH-1:0]  maximum_rate;
		logic [RATE_WIDTH-1:0]  average_rate;
		logic [TOTAL_WIDTH-1:0] sample_total;
		logic [ZONE_WIDTH-1:0]  zone;
		logic [1:0]             contact_status;
	} result_t;

endpackage

### design/hrsz_in_if.sv
interface hrsz_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] flags_byte;
	logic [7:0] rate_low_byte;
	logic [7:0] rate_high_byte;

	modport source (output valid, output flags_byte, output rate_low_byte,
		output rate_high_byte, input ready);
	modport sink (input valid, input flags_byte, input rate_low_byte,
		input rate_high_byte, output ready);
endinterface

### design/hrsz_out_if.sv
interface hrsz_out_if;
	logic                               valid;
	logic                               ready;
	logic [hrsz_pkg::RATE_WIDTH-1:0]    heart_rate;
	logic [hrsz_pkg::RATE_WIDTH-1:0]    minimum_rate;
	logic [hrsz_pkg::RATE_WIDTH-1:0]    maximum_rate;
	logic [hrsz_pkg::RATE_WIDTH-1:0]    average_rate;
	logic [hrsz_pkg::TOTAL_WIDTH-1:0]   sample_total;
	logic [hrsz_pkg::ZONE_WIDTH-1:0]    zone;
	logic [1:0]                         contact_status;

	modport source (output valid, output heart_rate, output minimum_rate,
		output maximum_rate, output average_rate, output sample_total,
		output zone, output contact_status, input ready);
	modport sink (input valid, input heart_rate, input minimum_rate,
		input maximum_rate, input average_rate, input sample_total,
		input zone, input contact_status, output ready);
endinterface

### design/hrsz_div.sv
module hrsz_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [hrsz_pkg::SUM_WIDTH-1:0]    dividend,
	input  logic [hrsz_pkg::COUNT_WIDTH-1:0]  divisor,
	output logic                              done,
	output logic [hrsz_pkg::RATE_WIDTH-1:0]   quotient
);

	logic                                busy_q;
	logic                                done_q;
	logic [hrsz_pkg::CNT_BITS-1:0]       step_q;
	logic [hrsz_pkg::COUNT_WIDTH-1:0]    rem_q;
	logic [hrsz_pkg::SUM_WIDTH-1:0]      quo_q;
	logic [hrsz_pkg::COUNT_WIDTH-1:0]    div_q;
	logic [hrsz_pkg::COUNT_WIDTH:0]      trial;
	logic [hrsz_pkg::COUNT_WIDTH:0]      diff;
	logic                                fits;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[hrsz_pkg::SUM_WIDTH-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	// Sequence one quotient bit a cycle, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= hrsz_pkg::CNT_BITS'(hrsz_pkg::SUM_WIDTH - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// Hold remainder and quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[hrsz_pkg::COUNT_WIDTH-1:0] : trial[hrsz_pkg::COUNT_WIDTH-1:0];
			quo_q <= {quo_q[hrsz_pkg::SUM_WIDTH-2:0], fits};
		end
	end

	// Mean never exceeds the largest rate, so the low bits carry it all
	assign done     = done_q;
	assign quotient = quo_q[hrsz_pkg::RATE_WIDTH-1:0];

endmodule

### design/hrsz_dpath.sv
module hrsz_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        flags_byte,
	input  logic [7:0]                        rate_low_byte,
	input  logic [7:0]                        rate_high_byte,
	input  logic                              cfg_we,
	input  logic [hrsz_pkg::IDX_WIDTH-1:0]    cfg_index,
	input  logic [hrsz_pkg::CFG_WIDTH-1:0]    cfg_data,
	input  hrsz_pkg::cmd_t                    cmd,
	output hrsz_pkg::sts_t                    sts,
	output hrsz_pkg::result_t                 result
);

	logic [hrsz_pkg::CFG_WIDTH-1:0]   bounds_q [hrsz_pkg::ZONE_COUNT];
	logic [hrsz_pkg::RATE_WIDTH-1:0]  last_q;
	logic [hrsz_pkg::RATE_WIDTH-1:0]  min_q;
	logic [hrsz_pkg::RATE_WIDTH-1:0]  max_q;
	logic [hrsz_pkg::SUM_WIDTH-1:0]   sum_q;
	logic [hrsz_pkg::COUNT_WIDTH-1:0] count_q;
	logic [hrsz_pkg::RATE_WIDTH-1:0]  mean_q;
	logic [hrsz_pkg::ZONE_WIDTH-1:0]  zone_q;
	logic [1:0]                       contact_q;
	logic                             acc_q;
	hrsz_pkg::result_t                result_q;

	logic [hrsz_pkg::RATE_WIDTH-1:0]  rate;
	logic [hrsz_pkg::SUM_WIDTH:0]     sum_next;
	logic                             acc_ok;
	logic [1:0]                       contact;
	logic [hrsz_pkg::ZONE_WIDTH-1:0]  zone_next;
	logic [63:0]                      count_ext;
	logic                             div_done;
	logic [hrsz_pkg::RATE_WIDTH-1:0]  quotient;

	// Assemble the rate from one or two bytes
	assign rate = flags_byte[hrsz_pkg::FLAG_WIDE_BIT] ? {rate_high_byte, rate_low_byte}
		: {8'h00, rate_low_byte};

	// Accumulate only nonzero rates, and only while count and sum have room
	assign sum_next = {1'b0, sum_q} + {{(hrsz_pkg::SUM_WIDTH + 1 - hrsz_pkg::RATE_WIDTH){1'b0}}, rate};
	assign acc_ok   = (rate != '0) && (count_q != hrsz_pkg::COUNT_MAX)
		&& !sum_next[hrsz_pkg::SUM_WIDTH];

	// Decode the contact bits
	always_comb begin
		unique case (flags_byte[2:1])
			hrsz_pkg::CONTACT_RAW_NONE: contact = hrsz_pkg::CONTACT_NO_CONTACT;
			hrsz_pkg::CONTACT_RAW_SEEN: contact = hrsz_pkg::CONTACT_DETECTED;
			default:                    contact = hrsz_pkg::CONTACT_UNSUPPORTED;
		endcase
	end

	// Pick the highest zone that strictly encloses the last rate, else keep the current zone
	always_comb begin
		zone_next = zone_q;
		for (int z = 0; z < hrsz_pkg::ZONE_COUNT; z++) begin
			if ((bounds_q[z][15:0] < last_q) && (bounds_q[z][31:16] > last_q))
				zone_next = hrsz_pkg::ZONE_WIDTH'(z + 1);
		end
	end

	// Write zone bounds; drop indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int z = 0; z < hrsz_pkg::ZONE_COUNT; z++)
				bounds_q[z] <= '0;
		end else if (cfg_we && (cfg_index < hrsz_pkg::IDX_WIDTH'(hrsz_pkg::ZONE_COUNT))) begin
			bounds_q[cfg_index] <= cfg_data;
		end
	end

	// Update statistics on each request, zone in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			min_q     <= '0;
			max_q     <= '0;
			sum_q     <= '0;
			count_q   <= '0;
			mean_q    <= '0;
			zone_q    <= '0;
			contact_q <= hrsz_pkg::CONTACT_UNSUPPORTED;
			acc_q     <= 1'b0;
		end else begin
			if (cmd.accept) begin
				last_q    <= rate;
				contact_q <= contact;
				acc_q     <= acc_ok;
				if (rate != '0) begin
					if ((min_q == '0) || (min_q > rate))
						min_q <= rate;
					if (max_q < rate)
						max_q <= rate;
				end
				if (acc_ok) begin
					sum_q   <= sum_next[hrsz_pkg::SUM_WIDTH-1:0];
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.zone_en)
				zone_q <= zone_next;
			if (cmd.mean_load)
				mean_q <= quotient;
		end
	end

	hrsz_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Saturate the reported count
	assign count_ext = 64'(count_q);

	// Hold the finished result for the output side
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.heart_rate     <= last_q;
			result_q.minimum_rate   <= min_q;
			result_q.maximum_rate   <= max_q;
			result_q.average_rate   <= mean_q;
			result_q.sample_total   <= (count_ext > 64'hFFFF_FFFF) ? '1
				: count_ext[hrsz_pkg::TOTAL_WIDTH-1:0];
			result_q.zone           <= zone_q;
			result_q.contact_status <= contact_q;
		end
	end

	assign result        = result_q;
	assign sts.acc_taken = acc_q;
	assign sts.div_done  = div_done;

endmodule

### design/hrsz_ctrl.sv
module hrsz_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	input  hrsz_pkg::sts_t  sts,
	output logic            in_ready,
	output logic            out_valid,
	output hrsz_pkg::cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ZONE = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_PUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	// Sequence one request: update, zone, divide when the sample was accumulated, hand off
	always_comb begin
		state_next    = state_q;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_next = ST_ZONE;
				end
			end
			ST_ZONE: begin
				cmd.zone_en = 1'b1;
				if (sts.acc_taken) begin
					cmd.div_start = 1'b1;
					state_next    = ST_DIV;
				end else begin
					state_next = ST_PUSH;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.mean_load = 1'b1;
					state_next    = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### design/heart_rate_stats_zone.sv
// Channel   Dir  Payload
// in_ch     in   flags_byte, rate_low_byte, rate_high_byte
// out_ch    out  heart_rate, minimum_rate, maximum_rate, average_rate,
//                sample_total, zone, contact_status
// cfg_*     in   cfg_we, cfg_index (zone register 0..4), cfg_data
//
// One request at a time: when the accumulators are frozen or the rate is
// zero the divide is skipped; when the average is recomputed, the 48-step
// restoring divider (one quotient bit per cycle) runs before the hand-off.
// A finished result waits in the output register while the next request
// is taken; the core stalls only if a second result is ready before the
// first one leaves. Reset clears statistics, zone bounds and all control.
module heart_rate_stats_zone (
	input  logic                            clk,
	input  logic                            arst_n,
	hrsz_in_if.sink                         in_ch,
	hrsz_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [hrsz_pkg::IDX_WIDTH-1:0]  cfg_index,
	input  logic [hrsz_pkg::CFG_WIDTH-1:0]  cfg_data
);

	hrsz_pkg::cmd_t    cmd;
	hrsz_pkg::sts_t    sts;
	hrsz_pkg::result_t result;

	hrsz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	hrsz_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.flags_byte     (in_ch.flags_byte),
		.rate_low_byte  (in_ch.rate_low_byte),
		.rate_high_byte (in_ch.rate_high_byte),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.sts            (sts),
		.result         (result)
	);

	// Drive the result channel payload
	assign out_ch.heart_rate     = result.heart_rate;
	assign out_ch.minimum_rate   = result.minimum_rate;
	assign out_ch.maximum_rate   = result.maximum_rate;
	assign out_ch.average_rate   = result.average_rate;
	assign out_ch.sample_total   = result.sample_total;
	assign out_ch.zone           = result.zone;
	assign out_ch.contact_status = result.contact_status;

endmodule
